### rtl/core/assert_macros.svh
// Assertion macros used by the duplicate filter table datapath.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/wdft_pkg.sv
// Package for the windowed duplicate filter table: word types, controller
// state encoding, command/status structs and reset constants. No dependencies.
`default_nettype none

package wdft_pkg;

  localparam int TABLE_SLOTS_DEF = 8;
  localparam int ADDR_W          = 48;
  localparam int BATCH_W         = 16;
  localparam int TIME_W          = 63;
  localparam int WINDOW_W        = 32;
  localparam int SLOT_OUT_W      = 3;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd8000000;

  // Input word.
  typedef struct packed {
    logic [ADDR_W-1:0]  sender_address;
    logic [BATCH_W-1:0] batch_number;
    logic [TIME_W-1:0]  now_time;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic                  is_duplicate;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  new_entry;
  } out_item_t;

  // One row of the slot memory.
  typedef struct packed {
    logic [ADDR_W-1:0]  sender_address;
    logic [BATCH_W-1:0] batch_number;
    logic [TIME_W-1:0]  stamp;
  } row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_JUDGE,
    ST_ALLOC
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic note_free;
    logic scan_next;
    logic finish_hit;
    logic finish_alloc;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/wdft_ctrl.sv
// Controller of the duplicate filter table: sequences accept, slot scan,
// window judgment and allocation. Depends on wdft_pkg.
`default_nettype none

module wdft_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output wdft_pkg::dp_cmd_t   cmd,
  input  wdft_pkg::dp_status_t status
);
  import wdft_pkg::*;

  ctrl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.note_free = 1'b1;
        if (status.hit) begin
          state_next = ST_JUDGE;
        end else if (status.last) begin
          state_next = ST_ALLOC;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_JUDGE: begin
        if (status.out_free) begin
          cmd.finish_hit = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        if (status.out_free) begin
          cmd.finish_alloc = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/wdft_dp.sv
// Datapath of the duplicate filter table: slot memory, valid bits, scan
// counter, window compare and output register. Depends on wdft_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wdft_dp #(
  parameter int TABLE_SLOTS = wdft_pkg::TABLE_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wdft_pkg::in_item_t                  in_data,
  input  logic                                window_we,
  input  logic [wdft_pkg::WINDOW_W-1:0]       window_wdata,
  input  wdft_pkg::dp_cmd_t                   cmd,
  output wdft_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wdft_pkg::out_item_t                 out_data
);
  import wdft_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  row_t                  mem [TABLE_SLOTS];
  row_t                  rd_q;
  row_t                  wr_row;
  in_item_t              item;
  logic [WINDOW_W-1:0]   window;
  logic [TABLE_SLOTS-1:0] valid;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_found;
  logic                  wr_en;
  logic [TIME_W:0]       elapsed;
  logic                  win_hit;
  logic                  dup;

  // Read address: slot 0 on accept, one ahead while scanning, else hold.
  always_comb begin
    if (cmd.load_item) begin
      rd_addr = '0;
    end else if (cmd.scan_next) begin
      rd_addr = idx + 1'b1;
    end else begin
      rd_addr = idx;
    end
  end

  // Elapsed time; a borrow means time went backwards and counts as inside.
  assign elapsed = {1'b0, item.now_time} - {1'b0, rd_q.stamp};
  assign win_hit = elapsed[TIME_W] |
                   (elapsed[TIME_W-1:0] < {{(TIME_W-WINDOW_W){1'b0}}, window});
  assign dup     = (rd_q.batch_number == item.batch_number) && win_hit;

  // Memory write: refresh a hit that is not a duplicate, or allocate.
  assign wr_en  = cmd.finish_alloc | (cmd.finish_hit & ~dup);
  assign wr_idx = cmd.finish_alloc ? (free_found ? free_idx : '0) : idx;
  assign wr_row = '{sender_address: item.sender_address,
                    batch_number:   item.batch_number,
                    stamp:          item.now_time};

  // Slot memory with registered read.
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.finish_alloc) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Captured input word.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
  end

  // Scan counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load_item) begin
      idx <= '0;
    end else if (cmd.scan_next) begin
      idx <= idx + 1'b1;
    end
  end

  // Lowest free slot seen during the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_found <= 1'b0;
    end else if (cmd.load_item) begin
      free_found <= 1'b0;
    end else if (cmd.note_free && !valid[idx] && !free_found) begin
      free_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.note_free && !valid[idx] && !free_found) begin
      free_idx <= idx;
    end
  end

  // Window register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (window_we) begin
      window <= window_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish_hit || cmd.finish_alloc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_hit) begin
      out_data <= '{is_duplicate: dup, slot_index: SLOT_OUT_W'(idx), new_entry: 1'b0};
    end else if (cmd.finish_alloc) begin
      out_data <= '{is_duplicate: 1'b0, slot_index: SLOT_OUT_W'(wr_idx), new_entry: 1'b1};
    end
  end

  // Status to the controller.
  assign status.hit      = valid[idx] && (rd_q.sender_address == item.sender_address);
  assign status.last     = (idx == LAST_IDX);
  assign status.out_free = ~out_valid | ~out_stall;

  // A result is loaded only into a free output register.
  `ASSERT_IMPL(a_out_free, clk, rst, cmd.finish_hit || cmd.finish_alloc, status.out_free)
  // A hit is only finished on a valid slot.
  `ASSERT_IMPL(a_hit_valid, clk, rst, cmd.finish_hit, valid[idx])
  // A recorded free slot is still free when allocation takes it.
  `ASSERT_IMPL(a_free_slot, clk, rst, cmd.finish_alloc && free_found, !valid[free_idx])
  // After a result is loaded the output word is presented.
  `ASSERT_NEXT(a_out_shown, clk, rst, cmd.finish_hit || cmd.finish_alloc, out_valid)

endmodule

`default_nettype wire

### rtl/core/windowed_duplicate_filter_table_core.sv
// A sender found in slot j gives its result after the scan reaches slot j and
// the judge state; an absent sender after a scan of every slot and the alloc
// state. Both states wait while the output is stalled. The scan reads one slot
// per cycle; no new word is taken until the result is loaded. rst clears the
// valid bits, output valid flag and controller, and loads the window with 8000000.
`default_nettype none

module windowed_duplicate_filter_table_core #(
  parameter int TABLE_SLOTS = wdft_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wdft_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wdft_pkg::out_item_t           out_data,
  input  logic                          window_we,
  input  logic [wdft_pkg::WINDOW_W-1:0] window_wdata
);
  import wdft_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  wdft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Slot table and result path.
  wdft_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_data      (in_data),
    .window_we    (window_we),
    .window_wdata (window_wdata),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire
